FILE: hw/rtl/gms_pkg.sv
// Shared types, codes and constants for the gripper motion sequencer.
// No dependencies; used by gms_cfg, gms_step, the top level and the testbench.
`timescale 1ns / 1ps

package gms_pkg;

  // Width of the elapsed-millisecond counter (8 to 32).
  localparam int TIMER_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH   = (TIMER_WIDTH > LIMIT_WIDTH) ? TIMER_WIDTH : LIMIT_WIDTH;

  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(3000);
  localparam logic                   LEVEL_RESET = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_TIMEOUT_LIMIT     = 1'b0,
    REG_REED_ACTIVE_LEVEL = 1'b1
  } gms_reg_t;

  typedef enum logic [2:0] {
    CMD_OPEN  = 3'd0,
    CMD_CLOSE = 3'd1,
    CMD_UP    = 3'd2,
    CMD_DOWN  = 3'd3,
    CMD_PICK  = 3'd4,
    CMD_PLACE = 3'd5,
    CMD_RSV6  = 3'd6,
    CMD_RSV7  = 3'd7
  } gms_cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_OPENING    = 4'd1,
    PH_CLOSING    = 4'd2,
    PH_UP         = 4'd3,
    PH_DOWN       = 4'd4,
    PH_PICK_DOWN  = 4'd5,
    PH_PICK_CLOSE = 4'd6,
    PH_PICK_UP    = 4'd7,
    PH_PLACE_DOWN = 4'd8,
    PH_PLACE_OPEN = 4'd9,
    PH_PLACE_UP   = 4'd10,
    PH_SUCCESS    = 4'd11,
    PH_TIMEOUT    = 4'd12
  } gms_phase_t;

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_COMMAND = 1'b1
  } gms_kind_t;

  typedef struct packed {
    logic open_drv;
    logic close_drv;
    logic up_drv;
    logic down_drv;
  } gms_drive_t;

  localparam gms_drive_t DRV_NONE  = '{1'b0, 1'b0, 1'b0, 1'b0};
  localparam gms_drive_t DRV_OPEN  = '{1'b1, 1'b0, 1'b0, 1'b0};
  localparam gms_drive_t DRV_CLOSE = '{1'b0, 1'b1, 1'b0, 1'b0};
  localparam gms_drive_t DRV_UP    = '{1'b0, 1'b0, 1'b1, 1'b0};
  localparam gms_drive_t DRV_DOWN  = '{1'b0, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    gms_phase_t             phase;
    logic                   busy;
    logic [TIMER_WIDTH-1:0] elapsed;
    gms_drive_t             drive;
  } gms_state_t;

  typedef struct packed {
    gms_kind_t kind;
    gms_cmd_t  code;
    logic      reed_closed;
    logic      reed_up;
    logic      reed_lower;
  } gms_item_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] timeout_limit;
    logic                   reed_active_level;
  } gms_cfg_t;

endpackage

FILE: hw/rtl/gms_cfg.sv
// Configuration register file of the gripper motion sequencer (APB-style).
// Depends on gms_pkg.
`timescale 1ns / 1ps

module gms_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gms_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [gms_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [gms_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  output gms_pkg::gms_cfg_t              cfg
);

  gms_pkg::gms_reg_t reg_sel;
  logic              wr_en;

  assign reg_sel = gms_pkg::gms_reg_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_limit     <= gms_pkg::LIMIT_RESET;
      cfg.reed_active_level <= gms_pkg::LEVEL_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        gms_pkg::REG_TIMEOUT_LIMIT: begin
          cfg.timeout_limit <= pwdata[gms_pkg::LIMIT_WIDTH-1:0];
        end
        gms_pkg::REG_REED_ACTIVE_LEVEL: begin
          cfg.reed_active_level <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      gms_pkg::REG_TIMEOUT_LIMIT:
        prdata = gms_pkg::DATA_WIDTH'(cfg.timeout_limit);
      gms_pkg::REG_REED_ACTIVE_LEVEL:
        prdata = gms_pkg::DATA_WIDTH'(cfg.reed_active_level);
      default:
        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/gms_step.sv
// Next-state logic of the gripper motion sequencer: one item against the state.
// Depends on gms_pkg.
`timescale 1ns / 1ps

module gms_step (
  input  gms_pkg::gms_state_t state,
  input  gms_pkg::gms_item_t  item,
  input  gms_pkg::gms_cfg_t   cfg,
  output gms_pkg::gms_state_t state_next,
  output logic                accepted
);

  localparam logic [gms_pkg::TIMER_WIDTH-1:0] TIMER_MAX = '1;

  logic                           closed;
  logic                           up;
  logic                           down;
  logic [gms_pkg::TIMER_WIDTH-1:0] elapsed_inc;
  logic                           timed_out;

  assign closed = (item.reed_closed == cfg.reed_active_level);
  assign up     = (item.reed_up == cfg.reed_active_level);
  assign down   = (item.reed_lower == cfg.reed_active_level);

  // Saturating count, then compare against the limit.
  assign elapsed_inc = (state.elapsed == TIMER_MAX) ? state.elapsed
                                                    : state.elapsed + 1'b1;
  assign timed_out   = gms_pkg::CMP_WIDTH'(elapsed_inc)
                       >= gms_pkg::CMP_WIDTH'(cfg.timeout_limit);

  always_comb begin
    state_next = state;
    accepted   = 1'b0;
    if (item.kind == gms_pkg::KIND_COMMAND) begin
      if (!state.busy) begin
        state_next.busy    = 1'b1;
        state_next.elapsed = '0;
        accepted           = 1'b1;
        case (item.code)
          gms_pkg::CMD_OPEN: begin
            state_next.phase = gms_pkg::PH_OPENING;
            state_next.drive = gms_pkg::DRV_OPEN;
          end
          gms_pkg::CMD_CLOSE: begin
            state_next.phase = gms_pkg::PH_CLOSING;
            state_next.drive = gms_pkg::DRV_CLOSE;
          end
          gms_pkg::CMD_UP: begin
            state_next.phase = gms_pkg::PH_UP;
            state_next.drive = gms_pkg::DRV_UP;
          end
          gms_pkg::CMD_DOWN: begin
            state_next.phase = gms_pkg::PH_DOWN;
            state_next.drive = gms_pkg::DRV_DOWN;
          end
          gms_pkg::CMD_PICK: begin
            state_next.phase = gms_pkg::PH_PICK_DOWN;
            state_next.drive = gms_pkg::DRV_DOWN;
          end
          gms_pkg::CMD_PLACE: begin
            state_next.phase = gms_pkg::PH_PLACE_DOWN;
            state_next.drive = gms_pkg::DRV_DOWN;
          end
          default: begin
            // Unknown code: reject, drop drives, keep phase and timer.
            state_next       = state;
            state_next.drive = gms_pkg::DRV_NONE;
            accepted         = 1'b0;
          end
        endcase
      end
    end else if (state.busy) begin
      state_next.elapsed = elapsed_inc;
      if (timed_out) begin
        state_next.phase = gms_pkg::PH_TIMEOUT;
        state_next.busy  = 1'b0;
        state_next.drive = gms_pkg::DRV_NONE;
      end else begin
        case (state.phase)
          gms_pkg::PH_OPENING, gms_pkg::PH_PICK_UP, gms_pkg::PH_PLACE_UP,
          gms_pkg::PH_CLOSING, gms_pkg::PH_UP, gms_pkg::PH_DOWN: begin
            if ((state.phase == gms_pkg::PH_OPENING && !closed) ||
                (state.phase == gms_pkg::PH_CLOSING && closed) ||
                (state.phase == gms_pkg::PH_DOWN && down) ||
                (state.phase != gms_pkg::PH_OPENING &&
                 state.phase != gms_pkg::PH_CLOSING &&
                 state.phase != gms_pkg::PH_DOWN && up)) begin
              state_next.phase = gms_pkg::PH_SUCCESS;
              state_next.busy  = 1'b0;
              state_next.drive = gms_pkg::DRV_NONE;
            end
          end
          gms_pkg::PH_PICK_DOWN: begin
            if (down) begin
              state_next.phase = gms_pkg::PH_PICK_CLOSE;
              state_next.drive = gms_pkg::DRV_CLOSE;
            end
          end
          gms_pkg::PH_PICK_CLOSE: begin
            if (closed) begin
              state_next.phase = gms_pkg::PH_PICK_UP;
              state_next.drive = gms_pkg::DRV_UP;
            end
          end
          gms_pkg::PH_PLACE_DOWN: begin
            if (down) begin
              state_next.phase = gms_pkg::PH_PLACE_OPEN;
              state_next.drive = gms_pkg::DRV_OPEN;
            end
          end
          gms_pkg::PH_PLACE_OPEN: begin
            if (!closed) begin
              state_next.phase = gms_pkg::PH_PLACE_UP;
              state_next.drive = gms_pkg::DRV_UP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/gripper_motion_sequencer_core.sv
// Top level of the gripper motion sequencer: input register, sequencer state,
// result register and configuration port. Depends on gms_pkg, gms_cfg, gms_step.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per item: either a
//   command (kind = 1, command_code) or a one-millisecond tick (kind = 0) with the
//   raw reed levels. Each item yields exactly one result transaction on the output
//   channel (out_valid/out_ready): accepted flag, the four valve drives, busy_res
//   and status, all showing the state after that item.
//   A transaction that is taken lands in the input register, is evaluated against
//   the sequencer state and is captured in the result register, raising out_valid.
//   Throughput: one item per cycle while out_ready holds; the state update is a
//   single pass through the next-state logic and the saturating timer compare.
//   When the receiver stalls, the result register holds its transaction and the
//   input register still takes one more; after that in_ready drops until the
//   result is taken. Nothing is lost or repeated.
//   The APB port writes timeout_limit (byte 0) and reed_active_level (byte 4);
//   write them only while no transaction is in flight.
//   Synchronous reset clears both valid flags, returns the sequencer to idle with
//   drives off and the timer at zero, and restores limit 3000 and active level 1.

module gripper_motion_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  // Item channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [2:0]                     command_code,
  input  logic                           reed_closed_pin,
  input  logic                           reed_up_pin,
  input  logic                           reed_down_pin,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic                           open_drive,
  output logic                           close_drive,
  output logic                           up_drive,
  output logic                           down_drive,
  output logic                           busy_res,
  output logic [3:0]                     status,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gms_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [gms_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [gms_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);

  gms_pkg::gms_cfg_t   cfg;
  gms_pkg::gms_item_t  item;        // input register payload
  logic                item_valid;
  gms_pkg::gms_state_t state;
  gms_pkg::gms_state_t state_next;
  logic                accepted_next;
  logic                advance;     // input register moves into the result register

  gms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gms_step u_step (
    .state      (state),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next),
    .accepted   (accepted_next)
  );

  // Advance when the result slot is empty or being drained this cycle.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register: hold the transaction until it is evaluated.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.kind        <= gms_pkg::gms_kind_t'(kind);
      item.code        <= gms_pkg::gms_cmd_t'(command_code);
      item.reed_closed <= reed_closed_pin;
      item.reed_up     <= reed_up_pin;
      item.reed_lower  <= reed_down_pin;
    end
  end

  // Sequencer state: update once per evaluated item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase   <= gms_pkg::PH_IDLE;
      state.busy    <= 1'b0;
      state.elapsed <= '0;
      state.drive   <= gms_pkg::DRV_NONE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: capture the post-item state, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      accepted    <= accepted_next;
      open_drive  <= state_next.drive.open_drv;
      close_drive <= state_next.drive.close_drv;
      up_drive    <= state_next.drive.up_drv;
      down_drive  <= state_next.drive.down_drv;
      busy_res    <= state_next.busy;
      status      <= state_next.phase;
    end
  end

  // A running sequence always energizes exactly one valve; idle drives none.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0(state.drive) && (state.busy == (state.drive != gms_pkg::DRV_NONE)))
    else $error("drive bits disagree with busy flag");

  // Not busy means the phase is at rest.
  assert property (@(posedge clk) disable iff (rst)
    !state.busy |-> (state.phase == gms_pkg::PH_IDLE ||
                     state.phase == gms_pkg::PH_SUCCESS ||
                     state.phase == gms_pkg::PH_TIMEOUT))
    else $error("idle sequencer left in an active phase");

  // An accepted command always reports a busy, freshly started sequence.
  assert property (@(posedge clk) disable iff (rst)
    advance && accepted_next |=> state.busy && (state.elapsed == '0) && accepted)
    else $error("accepted command did not start a sequence");

  // A stalled result must not be overwritten by a new evaluation.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

FILE: test/gms_result_checker.sv
// Result checker for the gripper motion sequencer: follows the item, result and
// configuration channels, predicts every result and compares it. Depends on gms_pkg.
`timescale 1ns / 1ps

module gms_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [2:0]                     command_code,
  input  logic                           reed_closed_pin,
  input  logic                           reed_up_pin,
  input  logic                           reed_down_pin,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           accepted,
  input  logic                           open_drive,
  input  logic                           close_drive,
  input  logic                           up_drive,
  input  logic                           down_drive,
  input  logic                           busy_res,
  input  logic [3:0]                     status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gms_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [gms_pkg::DATA_WIDTH-1:0] pwdata,
  input  logic [gms_pkg::DATA_WIDTH-1:0] prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             outstanding,
  output int                             checked
);

  import gms_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       accepted;
    gms_drive_t drive;
    logic       busy;
    gms_phase_t status;
  } gripper_outcome_t;

  logic [LIMIT_WIDTH-1:0] limit_ms;
  logic                   active_level;
  gms_phase_t             seq_phase;
  logic                   seq_busy;
  logic [TIMER_WIDTH-1:0] elapsed_ms;
  gms_drive_t             seq_drive;
  gripper_outcome_t       valve_status_q[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d: %s is %0d, predicted %0d",
                                checked, name, got, want));
  endtask

  // Advance the sequencer copy by one item and return the result it shows.
  function automatic gripper_outcome_t next_gripper_outcome(gms_kind_t item_kind,
                                                            gms_cmd_t code,
                                                            logic c_pin, logic u_pin,
                                                            logic d_pin);
    gripper_outcome_t res;
    logic             closed, up, down, took, moved;
    gms_phase_t       target;
    gms_drive_t       target_drive;
    closed       = (c_pin == active_level);
    up           = (u_pin == active_level);
    down         = (d_pin == active_level);
    took         = 1'b0;
    moved        = 1'b0;
    target       = seq_phase;
    target_drive = seq_drive;
    if (item_kind == KIND_COMMAND) begin
      if (!seq_busy && code <= CMD_PLACE) begin
        case (code)
          CMD_OPEN:  begin seq_phase = PH_OPENING;    seq_drive = DRV_OPEN;  end
          CMD_CLOSE: begin seq_phase = PH_CLOSING;    seq_drive = DRV_CLOSE; end
          CMD_UP:    begin seq_phase = PH_UP;         seq_drive = DRV_UP;    end
          CMD_DOWN:  begin seq_phase = PH_DOWN;       seq_drive = DRV_DOWN;  end
          CMD_PICK:  begin seq_phase = PH_PICK_DOWN;  seq_drive = DRV_DOWN;  end
          default:   begin seq_phase = PH_PLACE_DOWN; seq_drive = DRV_DOWN;  end
        endcase
        seq_busy   = 1'b1;
        elapsed_ms = '0;
        took       = 1'b1;
      end else if (!seq_busy) begin
        // rejected unknown code while idle: drives drop, phase and timer hold
        seq_drive = DRV_NONE;
      end
    end else if (seq_busy) begin
      if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
      if (CMP_WIDTH'(elapsed_ms) >= CMP_WIDTH'(limit_ms)) begin
        moved = 1'b1; target = PH_TIMEOUT; target_drive = DRV_NONE;
      end else begin
        case (seq_phase)
          PH_OPENING:    if (!closed) begin moved = 1'b1; target = PH_SUCCESS; end
          PH_CLOSING:    if (closed)  begin moved = 1'b1; target = PH_SUCCESS; end
          PH_UP:         if (up)      begin moved = 1'b1; target = PH_SUCCESS; end
          PH_DOWN:       if (down)    begin moved = 1'b1; target = PH_SUCCESS; end
          PH_PICK_DOWN:  if (down) begin
            moved = 1'b1; target = PH_PICK_CLOSE; target_drive = DRV_CLOSE;
          end
          PH_PICK_CLOSE: if (closed) begin
            moved = 1'b1; target = PH_PICK_UP; target_drive = DRV_UP;
          end
          PH_PICK_UP:    if (up) begin moved = 1'b1; target = PH_SUCCESS; end
          PH_PLACE_DOWN: if (down) begin
            moved = 1'b1; target = PH_PLACE_OPEN; target_drive = DRV_OPEN;
          end
          PH_PLACE_OPEN: if (!closed) begin
            moved = 1'b1; target = PH_PLACE_UP; target_drive = DRV_UP;
          end
          PH_PLACE_UP:   if (up) begin moved = 1'b1; target = PH_SUCCESS; end
          default: ;
        endcase
        if (target == PH_SUCCESS) target_drive = DRV_NONE;
      end
      if (moved) begin
        seq_phase = target;
        seq_drive = target_drive;
        if (target == PH_SUCCESS || target == PH_TIMEOUT) seq_busy = 1'b0;
      end
    end
    res.accepted = took;
    res.drive    = seq_drive;
    res.busy     = seq_busy;
    res.status   = seq_phase;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    gripper_outcome_t want;
    int               reg_value;
    if (rst) begin
      limit_ms     = LIMIT_RESET;
      active_level = LEVEL_RESET;
      seq_phase    = PH_IDLE;
      seq_busy     = 1'b0;
      elapsed_ms   = '0;
      seq_drive    = DRV_NONE;
      valve_status_q.delete();
    end else begin
      // Configuration writes are to land only while nothing is in flight; not enforced here.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if ((paddr >> 2) == ADDR_WIDTH'(REG_TIMEOUT_LIMIT)) limit_ms = pwdata[LIMIT_WIDTH-1:0];
          else active_level = pwdata[0];
        end else begin
          if ((paddr >> 2) == ADDR_WIDTH'(REG_TIMEOUT_LIMIT)) reg_value = int'(limit_ms);
          else reg_value = int'(active_level);
          if (prdata !== DATA_WIDTH'(reg_value))
            report_mismatch($sformatf("register read at %0d returned %0h, predicted %0h",
                                      paddr, prdata, reg_value));
        end
      end
      if (out_valid && out_ready) begin
        if (valve_status_q.size() == 0) begin
          report_mismatch("result transaction with no item waiting for it");
        end else begin
          want = valve_status_q.pop_front();
          check_field("accepted", accepted, want.accepted);
          check_field("open_drive", open_drive, want.drive.open_drv);
          check_field("close_drive", close_drive, want.drive.close_drv);
          check_field("up_drive", up_drive, want.drive.up_drv);
          check_field("down_drive", down_drive, want.drive.down_drv);
          check_field("busy_res", busy_res, want.busy);
          check_field("status", status, want.status);
          if ($isunknown({accepted, open_drive, close_drive, up_drive, down_drive,
                          busy_res, status}))
            report_mismatch("result carries unknown bits");
        end
        checked <= checked + 1;
      end
      if (in_valid && in_ready)
        valve_status_q.push_back(next_gripper_outcome(gms_kind_t'(kind),
                                                      gms_cmd_t'(command_code),
                                                      reed_closed_pin, reed_up_pin,
                                                      reed_down_pin));
    end
    outstanding <= valve_status_q.size();
  end

endmodule

FILE: test/tb_top.sv
// Top of the gripper motion sequencer testbench: clock, reset, item and
// configuration stimulus, verdict. Depends on gms_pkg, the core and gms_result_checker.
`timescale 1ns / 1ps

module tb_top;

  import gms_pkg::*;

  localparam int ITEM_TARGET    = 550;
  localparam int WATCHDOG_LIMIT = 1000;
  // Bit positions of the reed pins in a packed {closed, up, down} triple.
  localparam logic [1:0] SENSE_CLOSED = 2'd2;
  localparam logic [1:0] SENSE_UP     = 2'd1;
  localparam logic [1:0] SENSE_DOWN   = 2'd0;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic                  kind            = 1'b0;
  logic [2:0]            command_code    = '0;
  logic                  reed_closed_pin = 1'b0;
  logic                  reed_up_pin     = 1'b0;
  logic                  reed_down_pin   = 1'b0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic                  accepted;
  logic                  open_drive;
  logic                  close_drive;
  logic                  up_drive;
  logic                  down_drive;
  logic                  busy_res;
  logic [3:0]            status;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr           = '0;
  logic [DATA_WIDTH-1:0] pwdata          = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int   fail_count;
  int   outstanding;
  int   checked;
  int   idle_cycles  = 0;
  int   n_items      = 0;
  int   n_commands   = 0;
  int   n_settings   = 0;
  // Active reed level currently programmed; steers the well-formed sequences.
  logic active_level = LEVEL_RESET;
  // Set for whole stretches in which neither side idles.
  logic no_idle      = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gripper_motion_sequencer_core i_dut (
    .clk, .rst,
    .in_valid, .in_ready, .kind, .command_code,
    .reed_closed_pin, .reed_up_pin, .reed_down_pin,
    .out_valid, .out_ready, .accepted,
    .open_drive, .close_drive, .up_drive, .down_drive, .busy_res, .status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gms_result_checker i_checker (
    .clk, .rst,
    .in_valid, .in_ready, .kind, .command_code,
    .reed_closed_pin, .reed_up_pin, .reed_down_pin,
    .out_valid, .out_ready, .accepted,
    .open_drive, .close_drive, .up_drive, .down_drive, .busy_res, .status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .outstanding, .checked
  );

  // Offer one item after a random gap; hold it until the transaction completes.
  task automatic send_item(input gms_kind_t item_kind, input gms_cmd_t code,
                           input logic c_pin, input logic u_pin, input logic d_pin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    kind            <= item_kind;
    command_code    <= code;
    reed_closed_pin <= c_pin;
    reed_up_pin     <= u_pin;
    reed_down_pin   <= d_pin;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (item_kind == KIND_COMMAND) n_commands++;
  endtask

  // Reed levels in a command are don't-care: randomize them.
  task automatic send_cmd(input gms_cmd_t code);
    send_item(KIND_COMMAND, code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick(input logic c_pin, input logic u_pin, input logic d_pin);
    send_item(KIND_TICK, gms_cmd_t'($urandom_range(0, 7)), c_pin, u_pin, d_pin);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic is_write, input gms_reg_t index,
                            input logic [DATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_WIDTH'(index) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program both registers, then read them back for the checker.
  task automatic apply_setting(input logic [LIMIT_WIDTH-1:0] limit, input logic level);
    drain_results();
    apb_access(1'b1, REG_TIMEOUT_LIMIT, DATA_WIDTH'(limit));
    apb_access(1'b1, REG_REED_ACTIVE_LEVEL, DATA_WIDTH'(level));
    apb_access(1'b0, REG_TIMEOUT_LIMIT, '0);
    apb_access(1'b0, REG_REED_ACTIVE_LEVEL, '0);
    active_level = level;
    n_settings++;
  endtask

  // Issue a command and walk it through its steps: up to three ticks that miss the
  // awaited reed sense, then one that meets it. Now and then drop in a command
  // while busy, or abandon the sequence halfway.
  task automatic run_sequence(input gms_cmd_t code);
    int         n_steps;
    logic [1:0] sense[3];
    logic       want[3];
    int         miss;
    logic [2:0] pins;
    logic       met;
    n_steps = 0;
    case (code)
      CMD_OPEN:  begin n_steps = 1; sense[0] = SENSE_CLOSED; want[0] = 1'b0; end
      CMD_CLOSE: begin n_steps = 1; sense[0] = SENSE_CLOSED; want[0] = 1'b1; end
      CMD_UP:    begin n_steps = 1; sense[0] = SENSE_UP;     want[0] = 1'b1; end
      CMD_DOWN:  begin n_steps = 1; sense[0] = SENSE_DOWN;   want[0] = 1'b1; end
      CMD_PICK: begin
        n_steps = 3;
        sense[0] = SENSE_DOWN;   want[0] = 1'b1;
        sense[1] = SENSE_CLOSED; want[1] = 1'b1;
        sense[2] = SENSE_UP;     want[2] = 1'b1;
      end
      CMD_PLACE: begin
        n_steps = 3;
        sense[0] = SENSE_DOWN;   want[0] = 1'b1;
        sense[1] = SENSE_CLOSED; want[1] = 1'b0;
        sense[2] = SENSE_UP;     want[2] = 1'b1;
      end
      default: n_steps = 0;
    endcase
    send_cmd(code);
    for (int s = 0; s < n_steps; s++) begin
      if ($urandom_range(0, 11) == 0) return;
      miss = $urandom_range(0, 3);
      for (int k = 0; k <= miss; k++) begin
        if ($urandom_range(0, 9) == 0) send_cmd(gms_cmd_t'($urandom_range(0, 7)));
        pins = 3'($urandom_range(0, 7));
        met  = want[s] ? active_level : ~active_level;
        pins[sense[s]] = (k == miss) ? met : ~met;
        send_tick(pins[SENSE_CLOSED], pins[SENSE_UP], pins[SENSE_DOWN]);
      end
    end
  endtask

  // Result side: stall for a random gap before each transaction, unless no_idle is set.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, outstanding);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                     phase_no;
    int                     phase_end;
    int                     pick;
    logic [LIMIT_WIDTH-1:0] limit;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset settings (limit 3000, reeds active high).
    send_tick(1'b1, 1'b1, 1'b1);        // tick while idle: nothing moves
    send_cmd(CMD_RSV6);                 // unknown codes rejected while idle
    send_cmd(CMD_RSV7);
    send_cmd(CMD_OPEN);
    send_tick(1'b1, 1'b0, 1'b0);        // jaw still closed
    send_tick(1'b0, 1'b1, 1'b1);        // closed reed inactive: open done
    send_item(KIND_COMMAND, CMD_CLOSE, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_cmd(CMD_UP);
    send_tick(1'b0, 1'b1, 1'b0);
    send_cmd(CMD_DOWN);
    send_cmd(CMD_PICK);                 // busy: rejected
    send_cmd(CMD_RSV7);                 // busy and unknown: rejected
    send_tick(1'b0, 1'b0, 1'b1);
    send_cmd(CMD_PICK);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0);
    send_cmd(CMD_PLACE);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_cmd(CMD_RSV6);                 // after success: drives stay off
    send_tick(1'b1, 1'b1, 1'b1);

    // Limit zero with active-low reeds: the first busy tick times out.
    apply_setting('0, 1'b0);
    send_cmd(CMD_OPEN);
    send_tick(1'b1, 1'b1, 1'b1);
    send_cmd(CMD_PICK);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);

    // Limit one: timer is checked before the reed, so a met sense still times out.
    apply_setting(LIMIT_WIDTH'(1), 1'b1);
    send_cmd(CMD_CLOSE);
    send_tick(1'b1, 1'b1, 1'b1);

    // Random phases: mostly well-formed sequences, some noise.
    phase_no = 0;
    while (n_items < ITEM_TARGET) begin
      case (phase_no % 4)
        0:       limit = LIMIT_WIDTH'($urandom_range(2, 8));
        1:       limit = LIMIT_WIDTH'($urandom_range(9, 40));
        2:       limit = '1;
        default: limit = LIMIT_WIDTH'($urandom_range(1, 65535));
      endcase
      apply_setting(limit, 1'($urandom_range(0, 1)));
      no_idle   = (phase_no % 3 == 2);
      phase_end = n_items + 90;
      while (n_items < phase_end && n_items < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 72)
          run_sequence(gms_cmd_t'($urandom_range(0, 5)));
        else if (pick < 76)
          run_sequence(gms_cmd_t'($urandom_range(6, 7)));
        else
          send_item(gms_kind_t'($urandom_range(0, 1)), gms_cmd_t'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
      no_idle = 1'b0;
      phase_no++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d items (%0d commands), %0d results checked, %0d register settings",
             n_items, n_commands, checked, n_settings);
    $display("Limits from 0 to 65535, both reed polarities, random stalls on both channels");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
